/* hdl/tfd_pkg.sv */
// ----------------------------------------------------------------------------
// Telemetry frame deframer package
// Shared constants, CRC function, field table and inter-module structs.
// ----------------------------------------------------------------------------
package tfd_pkg;

	localparam logic [7:0]  SYNC_B0   = 8'hB0;
	localparam logic [7:0]  SYNC_B1   = 8'h1E;
	localparam logic [7:0]  SYNC_B2   = 8'hDE;
	localparam logic [7:0]  SYNC_B3   = 8'hAD;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [6:0]  CRC_SPAN  = 7'd95;
	localparam logic [6:0]  FRAME_LEN = 7'd97;
	localparam logic [4:0]  LAST_FIELD = 5'd28;

	typedef struct packed {
		logic [6:0] offset;
		logic [2:0] size;
		logic       sgn;
	} fdesc_t;

	// Front end to frame buffer.
	typedef struct packed {
		logic       en;
		logic [6:0] addr;
		logic [7:0] data;
		logic       push;
	} fe_wr_t;

	// Back end to frame buffer.
	typedef struct packed {
		logic [6:0] addr;
		logic       pop;
	} be_rd_t;

	// Frame buffer occupancy.
	typedef struct packed {
		logic full;
		logic nonempty;
	} fb_status_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
						   input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic fdesc_t field_desc(input logic [4:0] idx);
		fdesc_t d;
		unique case (idx)
			5'd0:  d = '{7'd8,  3'd4, 1'b1};
			5'd1:  d = '{7'd12, 3'd2, 1'b0};
			5'd2:  d = '{7'd14, 3'd2, 1'b1};
			5'd3:  d = '{7'd16, 3'd2, 1'b0};
			5'd4:  d = '{7'd18, 3'd2, 1'b1};
			5'd5:  d = '{7'd20, 3'd2, 1'b1};
			5'd6:  d = '{7'd22, 3'd2, 1'b1};
			5'd7:  d = '{7'd24, 3'd2, 1'b1};
			5'd8:  d = '{7'd26, 3'd2, 1'b1};
			5'd9:  d = '{7'd28, 3'd2, 1'b1};
			5'd10: d = '{7'd30, 3'd2, 1'b0};
			5'd11: d = '{7'd32, 3'd2, 1'b0};
			5'd12: d = '{7'd34, 3'd2, 1'b0};
			5'd13: d = '{7'd36, 3'd2, 1'b0};
			5'd14: d = '{7'd38, 3'd2, 1'b0};
			5'd15: d = '{7'd40, 3'd2, 1'b1};
			5'd16: d = '{7'd42, 3'd2, 1'b0};
			5'd17: d = '{7'd44, 3'd2, 1'b0};
			5'd18: d = '{7'd46, 3'd1, 1'b0};
			5'd19: d = '{7'd47, 3'd1, 1'b0};
			5'd20: d = '{7'd48, 3'd4, 1'b1};
			5'd21: d = '{7'd52, 3'd4, 1'b1};
			5'd22: d = '{7'd56, 3'd4, 1'b0};
			5'd23: d = '{7'd60, 3'd2, 1'b0};
			5'd24: d = '{7'd62, 3'd2, 1'b0};
			5'd25: d = '{7'd64, 3'd4, 1'b1};
			5'd26: d = '{7'd68, 3'd1, 1'b0};
			5'd27: d = '{7'd69, 3'd1, 1'b0};
			5'd28: d = '{7'd70, 3'd1, 1'b0};
			default: d = '{7'd0, 3'd1, 1'b0};
		endcase
		return d;
	endfunction

endpackage

/* hdl/tfd_byte_if.sv */
// ----------------------------------------------------------------------------
// Byte stream interface
// Carries one received byte per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

/* hdl/tfd_field_if.sv */
// ----------------------------------------------------------------------------
// Telemetry field interface
// Carries one decoded telemetry field per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tfd_field_if;
	logic              valid;
	logic              ready;
	logic [4:0]        field_id;
	logic signed [32:0] field_value;
	logic              last_field;

	modport source (output valid, output field_id, output field_value,
			output last_field, input ready);
	modport sink (input valid, input field_id, input field_value,
		      input last_field, output ready);
endinterface

/* hdl/telemetry_frame_deframer_crc16_top.sv */
// ----------------------------------------------------------------------------
// Telemetry frame deframer with CRC-16 check
// Parses a byte stream into 97-byte frames and emits their telemetry fields.
// ----------------------------------------------------------------------------
// The stream channel takes one received byte per word, one word per cycle
// while the frame memory has a free bank. The front end finds the start
// code B0 1E DE AD, stores the frame and runs CRC-16/CCITT over bytes 0 to
// 94 as they arrive. A frame whose CRC matches the little-endian value in
// bytes 95 and 96 is queued in a two-bank frame memory; a bad frame is
// discarded without output. The telemetry channel gives 29 words per good
// frame, field 0 to field 28, with last_field set on the final one. When
// the back end is idle, a queued frame starts it, and each field goes out
// through the frame memory read register and the output register. The back
// end reads one byte per cycle from the frame memory while it fetches a
// field and no stall holds it, so it reads a frame faster than one arrives.
// A stall on the telemetry channel holds the output register and the back
// end; bytes are still taken until both banks hold unread frames, and then
// the stream channel drops ready until the back end frees a bank.
// Reset returns the parser to start-code hunting and empties the frame queue.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer_crc16_top (
	input logic          clk,
	input logic          arst_n,
	tfd_byte_if.sink     stream,
	tfd_field_if.source  telemetry
);

	tfd_pkg::fe_wr_t     wr;
	tfd_pkg::be_rd_t     rd;
	tfd_pkg::fb_status_t status;
	logic [7:0]          rd_data;

	tfd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.status (status),
		.wr     (wr)
	);

	tfd_buffer u_buffer (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data),
		.status  (status)
	);

	tfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (status),
		.rd_data   (rd_data),
		.rd        (rd),
		.telemetry (telemetry)
	);

endmodule

/* hdl/tfd_front.sv */
// ----------------------------------------------------------------------------
// Deframer front end
// Hunts for the start code, writes frame bytes to the buffer and checks CRC.
// ----------------------------------------------------------------------------
module tfd_front (
	input  logic                clk,
	input  logic                arst_n,
	tfd_byte_if.sink            stream,
	input  tfd_pkg::fb_status_t status,
	output tfd_pkg::fe_wr_t     wr
);

	typedef enum logic [5:0] {
		FE_IDLE  = 6'b000001,
		FE_SYNC1 = 6'b000010,
		FE_SYNC2 = 6'b000100,
		FE_SYNC3 = 6'b001000,
		FE_SYNC4 = 6'b010000,
		FE_BODY  = 6'b100000
	} fe_state_t;

	fe_state_t   state_q;
	fe_state_t   nxt;
	logic [6:0]  cnt_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_lo_q;
	logic [6:0]  cnt_eff;
	logic [6:0]  cnt_inc;
	logic [15:0] crc_eff;
	logic [7:0]  c;
	logic        accept;
	logic        store;
	logic        done;

	assign stream.ready = !status.full;
	assign accept       = stream.valid && stream.ready;
	assign c            = stream.data_byte;

	always_comb begin
		nxt = state_q;
		unique case (state_q)
			FE_IDLE:  nxt = (c == tfd_pkg::SYNC_B0) ? FE_SYNC1 : FE_IDLE;
			FE_SYNC1: nxt = (c == tfd_pkg::SYNC_B1) ? FE_SYNC2 : FE_IDLE;
			FE_SYNC2: nxt = (c == tfd_pkg::SYNC_B2) ? FE_SYNC3 : FE_IDLE;
			FE_SYNC3: nxt = (c == tfd_pkg::SYNC_B3) ? FE_SYNC4 : FE_IDLE;
			FE_SYNC4: nxt = FE_BODY;
			FE_BODY:  nxt = FE_BODY;
			default:  nxt = FE_IDLE;
		endcase
	end

	assign cnt_eff = (state_q == FE_IDLE) ? 7'd0 : cnt_q;
	assign crc_eff = (state_q == FE_IDLE) ? tfd_pkg::CRC_INIT : crc_q;
	assign cnt_inc = cnt_eff + 7'd1;
	assign store   = accept && (nxt != FE_IDLE);
	assign done    = store && (cnt_inc == tfd_pkg::FRAME_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			cnt_q   <= 7'd0;
			crc_q   <= tfd_pkg::CRC_INIT;
		end else if (accept) begin
			state_q <= done ? FE_IDLE : nxt;
			if (store) begin
				cnt_q <= cnt_inc;
				if (cnt_eff < tfd_pkg::CRC_SPAN) begin
					crc_q <= tfd_pkg::crc_update(crc_eff, c);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store && (cnt_eff == tfd_pkg::CRC_SPAN)) begin
			crc_lo_q <= c;
		end
	end

	assign wr.en   = store;
	assign wr.addr = cnt_eff;
	assign wr.data = c;
	assign wr.push = done && ({c, crc_lo_q} == crc_q);

endmodule

/* hdl/tfd_buffer.sv */
// ----------------------------------------------------------------------------
// Deframer frame buffer
// Two-bank frame memory used as a two-entry queue of checked frames.
// ----------------------------------------------------------------------------
module tfd_buffer (
	input  logic                clk,
	input  logic                arst_n,
	input  tfd_pkg::fe_wr_t     wr,
	input  tfd_pkg::be_rd_t     rd,
	output logic [7:0]          rd_data,
	output tfd_pkg::fb_status_t status
);

	localparam logic [1:0] BANKS = 2'd2;

	logic [7:0] mem_q [0:255];
	logic [7:0] rd_data_q;
	logic       wr_bank_q;
	logic       rd_bank_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[{wr_bank_q, wr.addr}] <= wr.data;
		end
		rd_data_q <= mem_q[{rd_bank_q, rd.addr}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_bank_q <= 1'b0;
			rd_bank_q <= 1'b0;
			count_q   <= 2'd0;
		end else begin
			if (wr.push) begin
				wr_bank_q <= !wr_bank_q;
			end
			if (rd.pop) begin
				rd_bank_q <= !rd_bank_q;
			end
			if (wr.push && !rd.pop) begin
				count_q <= count_q + 2'd1;
			end else if (rd.pop && !wr.push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign rd_data         = rd_data_q;
	assign status.full     = (count_q == BANKS);
	assign status.nonempty = (count_q != 2'd0);

endmodule

/* hdl/tfd_back.sv */
// ----------------------------------------------------------------------------
// Deframer back end
// Reads a checked frame byte by byte and emits its telemetry fields in order.
// ----------------------------------------------------------------------------
module tfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tfd_pkg::fb_status_t status,
	input  logic [7:0]          rd_data,
	output tfd_pkg::be_rd_t     rd,
	tfd_field_if.source         telemetry
);

	typedef enum logic [2:0] {
		BE_IDLE = 3'b001,
		BE_READ = 3'b010,
		BE_HOLD = 3'b100
	} be_state_t;

	be_state_t         state_q;
	logic [4:0]        fidx_q;
	logic [1:0]        k_q;
	logic [31:0]       acc_q;
	logic              rvld_s1;
	logic              out_vld_q;
	logic [4:0]        out_id_q;
	logic signed [32:0] out_val_q;
	logic              out_last_q;
	tfd_pkg::fdesc_t   desc;
	logic [31:0]       acc_next;
	logic [31:0]       src;
	logic              s;
	logic [32:0]       val;
	logic              slot_free;
	logic              emit;

	assign desc      = tfd_pkg::field_desc(fidx_q);
	assign rd.addr   = desc.offset + {5'd0, k_q};
	assign acc_next  = {acc_q[23:0], rd_data};
	assign src       = rvld_s1 ? acc_next : acc_q;
	assign slot_free = !out_vld_q || telemetry.ready;
	assign emit      = (state_q == BE_HOLD) && slot_free;
	assign rd.pop    = emit && (fidx_q == tfd_pkg::LAST_FIELD);

	always_comb begin
		case (desc.size)
			3'd1: begin
				s   = desc.sgn & src[7];
				val = {{25{s}}, src[7:0]};
			end
			3'd2: begin
				s   = desc.sgn & src[15];
				val = {{17{s}}, src[15:0]};
			end
			default: begin
				s   = desc.sgn & src[31];
				val = {s, src[31:0]};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BE_IDLE;
			fidx_q    <= 5'd0;
			k_q       <= 2'd0;
			rvld_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rvld_s1 <= (state_q == BE_READ);
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (telemetry.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				BE_IDLE: begin
					fidx_q <= 5'd0;
					k_q    <= 2'd0;
					if (status.nonempty) begin
						state_q <= BE_READ;
					end
				end
				BE_READ: begin
					if ({1'b0, k_q} == desc.size - 3'd1) begin
						state_q <= BE_HOLD;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				BE_HOLD: begin
					if (emit) begin
						k_q <= 2'd0;
						if (fidx_q == tfd_pkg::LAST_FIELD) begin
							state_q <= BE_IDLE;
						end else begin
							fidx_q  <= fidx_q + 5'd1;
							state_q <= BE_READ;
						end
					end
				end
				default: state_q <= BE_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_s1) begin
			acc_q <= acc_next;
		end
		if (emit) begin
			out_id_q   <= fidx_q;
			out_val_q  <= val;
			out_last_q <= (fidx_q == tfd_pkg::LAST_FIELD);
		end
	end

	assign telemetry.valid       = out_vld_q;
	assign telemetry.field_id    = out_id_q;
	assign telemetry.field_value = out_val_q;
	assign telemetry.last_field  = out_last_q;

endmodule
